@@ hdl/mppc_pkg.sv @@
// Shared types and constants for the media payload pattern checker.
// Used by mppc_ctrl, mppc_dpath and media_payload_pattern_checker_top; no dependencies.
package mppc_pkg;

   // Payload size limit and the byte counter width that holds it
   localparam int unsigned MAX_PAYLOAD_BYTES = 131072;
   localparam int unsigned POS_W = $clog2(MAX_PAYLOAD_BYTES + 1);

   typedef logic [POS_W-1:0] pos_type;

   // Lead byte codes
   localparam logic [7:0] LEAD_AUDIO       = 8'hAF;
   localparam logic [7:0] LEAD_VIDEO_KEY   = 8'h17;
   localparam logic [7:0] LEAD_VIDEO_INTER = 8'h27;

   // Packet type codes
   localparam logic [7:0] KIND_HEADER = 8'h00;
   localparam logic [7:0] KIND_DATA   = 8'h01;

   // Expected byte 5 of a video header packet
   localparam logic [7:0] HDR_VERSION = 8'h01;

   // Unit header tags
   localparam logic [7:0] TAG_KEY   = 8'h65;
   localparam logic [7:0] TAG_INTER = 8'h41;

   // Byte positions within a payload
   localparam pos_type POS_LEAD      = pos_type'(0);
   localparam pos_type POS_KIND      = pos_type'(1);
   localparam pos_type POS_AUDIO_LEN = pos_type'(3);
   localparam pos_type POS_VID_MIN   = pos_type'(4);
   localparam pos_type POS_LEN_FIRST = pos_type'(5);
   localparam pos_type POS_LEN_LAST  = pos_type'(8);
   localparam pos_type POS_TAG       = pos_type'(9);
   localparam pos_type AUDIO_BODY    = pos_type'(2);
   localparam pos_type VIDEO_BODY    = pos_type'(10);
   localparam pos_type POS_LIMIT     = pos_type'(MAX_PAYLOAD_BYTES);

   // Pattern mix constants
   localparam logic [31:0] MIX_K1 = 32'd2654435761;
   localparam logic [31:0] MIX_K2 = 32'd40503;
   localparam logic [31:0] MIX_K3 = 32'd1274126177;
   localparam logic [31:0] LEN_BIAS = 32'd8;

   // Commands from controller to datapath
   typedef struct packed {
      logic accept;   // latch a new beat and form the first mix product
      logic commit;   // fold the beat into the payload state
   } ctl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic last;     // held beat closes the payload
   } dp_status_type;

endpackage

@@ hdl/media_payload_pattern_checker_top.sv @@
// Media payload pattern checker: one pass/fail verdict per byte-serial payload.
// Verdicts are registered; a held closing byte commits once the result slot is free.
// A new byte waits until the held one commits; the first of two dependent 32-bit mix
// multiplies is registered; a pending verdict stalls only a closing byte.
// Reset (synchronous, active high) clears the payload state and the result slot.
// Depends on mppc_pkg, mppc_ctrl and mppc_dpath.
module media_payload_pattern_checker_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_payload_ok
);

   mppc_pkg::ctl_cmd_type   cmd;
   mppc_pkg::dp_status_type status;

   mppc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   mppc_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_data_byte  (req_data_byte),
      .req_last_byte  (req_last_byte),
      .cmd            (cmd),
      .status         (status),
      .rsp_payload_ok (rsp_payload_ok)
   );

endmodule

@@ hdl/mppc_ctrl.sv @@
// Controller for the media payload pattern checker: beat sequencing and result slot.
// Depends on mppc_pkg.
module mppc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output mppc_pkg::ctl_cmd_type   cmd,
   input  mppc_pkg::dp_status_type status
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_WORK = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;

   // Result slot frees when empty or when its beat is taken now
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Issue commands
   always_comb begin
      cmd.accept = (state_ff == S_IDLE) && req_valid;
      cmd.commit = (state_ff == S_WORK) && (!status.last || slot_free);
   end

   // Advance the state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.accept) state_in = S_WORK;
         end
         S_WORK: begin
            if (cmd.commit) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold the result until taken
   always_comb begin
      if (cmd.commit && status.last) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hdl/mppc_dpath.sv @@
// Datapath for the media payload pattern checker: payload state, pattern mix, verdict.
// Depends on mppc_pkg.
module mppc_dpath (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [7:0]               req_data_byte,
   input  logic                     req_last_byte,
   input  mppc_pkg::ctl_cmd_type    cmd,
   output mppc_pkg::dp_status_type  status,
   output logic                     rsp_payload_ok
);

   // Held beat and first mix product
   logic [7:0]  data_ff;
   logic        last_ff;
   logic [31:0] mix1_ff, mix1_in;

   // Payload state
   mppc_pkg::pos_type pos_ff, pos_in;
   logic [7:0]  lead_ff, lead_in;
   logic [7:0]  kind_ff, kind_in;
   logic [31:0] ulen_ff, ulen_in;
   logic [7:0]  tag_ff, tag_in;
   logic        fail_ff, fail_in;
   logic        ok_ff;

   mppc_pkg::pos_type body_pos;
   logic [7:0]  mix_tag;
   logic [31:0] mix_shr, mix2;
   logic [7:0]  pattern;
   logic        sat;
   logic        lead_known;
   logic        shape_ok;
   logic [31:0] len_expect;

   // First stage: position and tag into one word
   always_comb begin
      if (lead_ff == mppc_pkg::LEAD_AUDIO) begin
         body_pos = pos_ff - mppc_pkg::AUDIO_BODY;
         mix_tag  = mppc_pkg::LEAD_AUDIO;
      end else begin
         body_pos = pos_ff - mppc_pkg::VIDEO_BODY;
         mix_tag  = tag_ff;
      end
      mix1_in = 32'(body_pos) * mppc_pkg::MIX_K1 + 32'(mix_tag) * mppc_pkg::MIX_K2;
   end

   // Second stage: xorshift, multiply, fold to a byte
   always_comb begin
      mix_shr = mix1_ff ^ (mix1_ff >> 13);
      mix2    = mix_shr * mppc_pkg::MIX_K3;
      pattern = mix2[7:0] ^ mix2[23:16];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         data_ff <= req_data_byte;
         last_ff <= req_last_byte;
         mix1_ff <= mix1_in;
      end
   end

   assign status.last = last_ff;

   // Fold the held beat into the payload state
   always_comb begin
      sat     = (pos_ff >= mppc_pkg::POS_LIMIT);
      pos_in  = pos_ff;
      lead_in = lead_ff;
      kind_in = kind_ff;
      ulen_in = ulen_ff;
      tag_in  = tag_ff;
      fail_in = fail_ff;
      lead_known = (data_ff == mppc_pkg::LEAD_AUDIO) ||
                   (data_ff == mppc_pkg::LEAD_VIDEO_KEY) ||
                   (data_ff == mppc_pkg::LEAD_VIDEO_INTER);
      if (sat) begin
         fail_in = 1'b1;
      end else begin
         pos_in = pos_ff + mppc_pkg::pos_type'(1);
         priority if (pos_ff == mppc_pkg::POS_LEAD) begin
            lead_in = data_ff;
            if (!lead_known) fail_in = 1'b1;
         end else if (pos_ff == mppc_pkg::POS_KIND) begin
            kind_in = data_ff;
            if (data_ff != mppc_pkg::KIND_HEADER && data_ff != mppc_pkg::KIND_DATA) begin
               fail_in = 1'b1;
            end
         end else if (lead_ff == mppc_pkg::LEAD_AUDIO) begin
            if (kind_ff == mppc_pkg::KIND_DATA && data_ff != pattern) fail_in = 1'b1;
         end else if (kind_ff == mppc_pkg::KIND_HEADER) begin
            if (pos_ff == mppc_pkg::POS_LEN_FIRST && data_ff != mppc_pkg::HDR_VERSION) begin
               fail_in = 1'b1;
            end
         end else if (pos_ff >= mppc_pkg::POS_LEN_FIRST && pos_ff <= mppc_pkg::POS_LEN_LAST) begin
            ulen_in = {ulen_ff[23:0], data_ff};
         end else if (pos_ff == mppc_pkg::POS_TAG) begin
            tag_in = data_ff;
            if (lead_ff == mppc_pkg::LEAD_VIDEO_KEY) begin
               if (data_ff != mppc_pkg::TAG_KEY) fail_in = 1'b1;
            end else begin
               if (data_ff != mppc_pkg::TAG_INTER) fail_in = 1'b1;
            end
         end else if (pos_ff >= mppc_pkg::VIDEO_BODY) begin
            if (data_ff != pattern) fail_in = 1'b1;
         end
      end
   end

   // Judge length and layout on the closing beat
   always_comb begin
      len_expect = 32'(pos_ff) - mppc_pkg::LEN_BIAS;
      if (lead_in == mppc_pkg::LEAD_AUDIO) begin
         if (pos_ff == mppc_pkg::POS_LEAD) begin
            shape_ok = 1'b0;
         end else if (kind_in == mppc_pkg::KIND_HEADER) begin
            shape_ok = (pos_ff == mppc_pkg::POS_AUDIO_LEN);
         end else begin
            shape_ok = 1'b1;
         end
      end else if (pos_ff < mppc_pkg::POS_VID_MIN) begin
         shape_ok = 1'b0;
      end else if (kind_in == mppc_pkg::KIND_HEADER) begin
         shape_ok = (pos_ff >= mppc_pkg::POS_LEN_FIRST);
      end else begin
         shape_ok = (pos_ff >= mppc_pkg::POS_TAG) && (ulen_in != '0) &&
                    (ulen_in == len_expect);
      end
   end

   // Commit: clear after a verdict, else keep the updated state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         lead_ff <= '0;
         kind_ff <= '0;
         ulen_ff <= '0;
         tag_ff  <= '0;
         fail_ff <= 1'b0;
      end else if (cmd.commit) begin
         if (last_ff) begin
            pos_ff  <= '0;
            lead_ff <= '0;
            kind_ff <= '0;
            ulen_ff <= '0;
            tag_ff  <= '0;
            fail_ff <= 1'b0;
         end else begin
            pos_ff  <= pos_in;
            lead_ff <= lead_in;
            kind_ff <= kind_in;
            ulen_ff <= ulen_in;
            tag_ff  <= tag_in;
            fail_ff <= fail_in;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.commit && last_ff) begin
         ok_ff <= !fail_in && shape_ok;
      end
   end

   assign rsp_payload_ok = ok_ff;

endmodule

@@ verif/mppc_verdict_checker.sv @@
`timescale 1ns / 100ps
// Payload pattern function and verdict checker for media_payload_pattern_checker_top.
// Watches both channels, predicts the verdict of every payload and compares it.
// Depends on mppc_pkg.
package mppc_pattern_pkg;
   import mppc_pkg::*;

   // Body byte expected at a body position for a given tag
   function automatic logic [7:0] body_pattern(logic [31:0] body_pos, logic [7:0] tag);
      logic [31:0] h;
      h = body_pos * MIX_K1 + {24'd0, tag} * MIX_K2;
      h = h ^ (h >> 13);
      h = h * MIX_K3;
      h = h ^ (h >> 16);
      return h[7:0];
   endfunction

endpackage

module mppc_verdict_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_payload_ok,
   output int         mismatch_count,
   output int         verdicts_due
);
   import mppc_pkg::*;
   import mppc_pattern_pkg::*;

   localparam int SHOW_LIMIT = 10;

   // Predicted payload state
   pos_type     byte_pos;
   logic [7:0]  lead_seen;
   logic [7:0]  kind_seen;
   logic [31:0] unit_len;
   logic [7:0]  unit_tag;
   logic        broken;
   bit          verdict_q[$];
   int          shown;

   function automatic void clear_payload();
      byte_pos  = '0;
      lead_seen = '0;
      kind_seen = '0;
      unit_len  = '0;
      unit_tag  = '0;
      broken    = 1'b0;
   endfunction

   // Fold one accepted beat into the payload; queue a verdict on the closing beat
   function automatic void fold_beat(logic [7:0] d, logic last);
      pos_type    p;
      logic [7:0] want_tag;
      logic       ok;
      p = byte_pos;
      if (p >= POS_LIMIT) begin
         broken = 1'b1;
      end else begin
         if (p == POS_LEAD) begin
            lead_seen = d;
            if (d != LEAD_AUDIO && d != LEAD_VIDEO_KEY && d != LEAD_VIDEO_INTER)
               broken = 1'b1;
         end else if (p == POS_KIND) begin
            kind_seen = d;
            if (d != KIND_HEADER && d != KIND_DATA)
               broken = 1'b1;
         end else if (lead_seen == LEAD_AUDIO) begin
            if (kind_seen == KIND_DATA && d != body_pattern(32'(p - AUDIO_BODY), LEAD_AUDIO))
               broken = 1'b1;
         end else if (kind_seen == KIND_HEADER) begin
            if (p == POS_LEN_FIRST && d != HDR_VERSION)
               broken = 1'b1;
         end else if (p >= POS_LEN_FIRST && p <= POS_LEN_LAST) begin
            unit_len = {unit_len[23:0], d};
         end else if (p == POS_TAG) begin
            unit_tag = d;
            want_tag = (lead_seen == LEAD_VIDEO_KEY) ? TAG_KEY : TAG_INTER;
            if (d != want_tag)
               broken = 1'b1;
         end else if (p >= VIDEO_BODY) begin
            if (d != body_pattern(32'(p - VIDEO_BODY), unit_tag))
               broken = 1'b1;
         end
         byte_pos = p + 1'b1;
      end

      if (last) begin
         if (lead_seen == LEAD_AUDIO)
            ok = (p >= POS_KIND) && (kind_seen != KIND_HEADER || p == POS_AUDIO_LEN);
         else if (kind_seen == KIND_HEADER)
            ok = (p > POS_VID_MIN);
         else
            ok = (p >= POS_TAG) && (unit_len != 0) &&
                 (33'(p) == {1'b0, unit_len} + 33'(LEN_BIAS));
         verdict_q.insert(verdict_q.size(), !broken && ok);
         clear_payload();
      end
   endfunction

   // Predict on accepted beats, compare accepted verdicts
   always @(posedge clock) begin
      bit want;
      if (reset) begin
         clear_payload();
         verdict_q.delete();
         mismatch_count <= 0;
         shown = 0;
      end else begin
         if (req_valid && !req_stall)
            fold_beat(req_data_byte, req_last_byte);
         if (rsp_valid && !rsp_stall) begin
            if (verdict_q.size() == 0) begin
               if (shown < SHOW_LIMIT)
                  $display("%0t: verdict with none pending: got %0b", $time, rsp_payload_ok);
               shown++;
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = verdict_q.pop_front();
               if (rsp_payload_ok !== want) begin
                  if (shown < SHOW_LIMIT)
                     $display("%0t: verdict mismatch: expected %0b, got %0b",
                              $time, want, rsp_payload_ok);
                  shown++;
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
      verdicts_due <= verdict_q.size();
   end

endmodule

@@ verif/media_payload_pattern_checker_top_tb.sv @@
`timescale 1ns / 100ps
// Stimulus and verdict for media_payload_pattern_checker_top.
// Depends on mppc_pkg, mppc_pattern_pkg and mppc_verdict_checker.
module media_payload_pattern_checker_top_tb;
   import mppc_pkg::*;
   import mppc_pattern_pkg::*;

   localparam int HALF_PERIOD    = 4;
   localparam int RANDOM_BYTES   = 1100;
   localparam int FINAL_BYTES    = 120;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = '0;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_payload_ok;

   int         mismatch_count;
   int         verdicts_due;
   bit         idle_on = 1'b0;
   int         stall_left = 0;
   int         quiet_cycles = 0;
   int         stimulus_bytes = 0;
   logic [7:0] payload_bytes[$];

   always #(HALF_PERIOD) clock = ~clock;

   media_payload_pattern_checker_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload_ok (rsp_payload_ok)
   );

   mppc_verdict_checker i_verdict_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload_ok (rsp_payload_ok),
      .mismatch_count (mismatch_count),
      .verdicts_due   (verdicts_due)
   );

   // Stall the verdict channel in short random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (idle_on && $urandom_range(4, 0) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(3, 0);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // End the run when nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("media_payload_pattern_checker_top_tb: errors");
         $finish;
      end
   end

   // Append one byte to the payload under construction
   function automatic void add_byte(logic [7:0] b);
      payload_bytes.insert(payload_bytes.size(), b);
   endfunction

   // Offer one beat, with an optional idle gap, and hold it until taken
   task automatic send_beat(logic [7:0] d, logic last);
      if (idle_on && $urandom_range(3, 0) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= d;
      req_last_byte <= last;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      stimulus_bytes++;
   endtask

   task automatic send_payload();
      int i;
      for (i = 0; i < payload_bytes.size(); i++)
         send_beat(payload_bytes[i], i == payload_bytes.size() - 1);
   endtask

   // Build a mostly well-formed payload with random content, then maybe damage it
   task automatic make_random_payload();
      int          sel;
      int          n;
      int          k;
      logic [7:0]  lead;
      logic [7:0]  tag;
      logic [31:0] ulen;
      payload_bytes.delete();
      sel  = $urandom_range(9, 0);
      lead = $urandom_range(1, 0) ? LEAD_VIDEO_KEY : LEAD_VIDEO_INTER;
      case (sel)
         0, 1: begin
            payload_bytes = '{LEAD_AUDIO, KIND_HEADER};
            add_byte(8'($urandom_range(255, 0)));
            add_byte(8'($urandom_range(255, 0)));
         end
         2, 3: begin
            payload_bytes = '{LEAD_AUDIO, KIND_DATA};
            n = $urandom_range(24, 0);
            for (k = 0; k < n; k++)
               add_byte(body_pattern(k, LEAD_AUDIO));
         end
         4, 5: begin
            payload_bytes = '{lead, KIND_HEADER};
            repeat (3) add_byte(8'($urandom_range(255, 0)));
            add_byte(HDR_VERSION);
            repeat ($urandom_range(6, 0)) add_byte(8'($urandom_range(255, 0)));
         end
         6, 7, 8: begin
            tag  = (lead == LEAD_VIDEO_KEY) ? TAG_KEY : TAG_INTER;
            ulen = $urandom_range(20, 1);
            payload_bytes = '{lead, KIND_DATA};
            repeat (3) add_byte(8'($urandom_range(255, 0)));
            add_byte(ulen[31:24]);
            add_byte(ulen[23:16]);
            add_byte(ulen[15:8]);
            add_byte(ulen[7:0]);
            add_byte(tag);
            for (k = 0; k < ulen - 1; k++)
               add_byte(body_pattern(k, tag));
         end
         default: begin
            n = $urandom_range(14, 1);
            repeat (n) add_byte(8'($urandom_range(255, 0)));
            if ($urandom_range(1, 0))
               payload_bytes[0] = $urandom_range(1, 0) ? LEAD_AUDIO : lead;
         end
      endcase

      // Damage about one payload in four
      if ($urandom_range(3, 0) == 0) begin
         case ($urandom_range(3, 0))
            0: begin
               k = $urandom_range(payload_bytes.size() - 1, 0);
               payload_bytes[k] = payload_bytes[k] ^ (8'h01 << $urandom_range(7, 0));
            end
            1: repeat ($urandom_range(payload_bytes.size() - 1, 0)) void'(payload_bytes.pop_back());
            2: repeat ($urandom_range(3, 1)) add_byte(8'($urandom_range(255, 0)));
            default: begin
               k = $urandom_range(payload_bytes.size() > 1 ? 1 : 0, 0);
               payload_bytes[k] = 8'($urandom_range(255, 0));
            end
         endcase
      end
   endtask

   // Audio data payload of a given length with a correct body
   task automatic make_long_audio(int len);
      int k;
      payload_bytes = '{LEAD_AUDIO, KIND_DATA};
      for (k = 0; k < len - 2; k++)
         add_byte(body_pattern(k, LEAD_AUDIO));
   endtask

   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: each payload kind, too-short and unknown-lead cases
      idle_on = 1'b1;
      payload_bytes = '{LEAD_AUDIO, KIND_HEADER, 8'h00, 8'hFF};
      send_payload();
      payload_bytes = '{LEAD_AUDIO};
      send_payload();
      payload_bytes = '{LEAD_VIDEO_KEY, KIND_HEADER, 8'hFF, 8'h00, 8'hFF, HDR_VERSION};
      send_payload();
      payload_bytes = '{LEAD_VIDEO_INTER, KIND_DATA, 8'h00, 8'h00, 8'h00,
                        8'h00, 8'h00, 8'h00, 8'h01, TAG_INTER};
      send_payload();
      payload_bytes = '{8'hFF};
      send_payload();
      make_long_audio(4);
      send_payload();

      // Hold the sender until every verdict is back
      req_valid <= 1'b0;
      while (verdicts_due != 0) @(negedge clock);

      // Random payloads, some stretches without idling
      stimulus_bytes = 0;
      while (stimulus_bytes < RANDOM_BYTES) begin
         idle_on = ($urandom_range(3, 0) != 0);
         make_random_payload();
         send_payload();
      end

      // Last stretch without idling on either side
      idle_on = 1'b0;
      while (stimulus_bytes < RANDOM_BYTES + FINAL_BYTES) begin
         make_random_payload();
         send_payload();
      end

      // Drain
      req_valid <= 1'b0;
      while (verdicts_due != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("media_payload_pattern_checker_top_tb: clean");
      else
         $display("media_payload_pattern_checker_top_tb: errors");
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/mppc_pkg.sv
hdl/mppc_ctrl.sv
hdl/mppc_dpath.sv
hdl/media_payload_pattern_checker_top.sv
verif/mppc_verdict_checker.sv
verif/media_payload_pattern_checker_top_tb.sv
